@@ hw/rtl/lbpf_pkg.sv @@
package lbpf_pkg;

  // Input commands
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_SET     = 2'd1;
  localparam logic [1:0] CMD_ALL_OFF = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_BLINK_SLOW  = 3'd0;
  localparam logic [2:0] REG_BLINK_MED   = 3'd1;
  localparam logic [2:0] REG_BLINK_FAST  = 3'd2;
  localparam logic [2:0] REG_PULSE_INTVL = 3'd3;
  localparam logic [2:0] REG_FADE_INTVL  = 3'd4;
  localparam logic [2:0] REG_BRIGHT_STEP = 3'd5;
  localparam logic [2:0] REG_PULSE_FLOOR = 3'd6;

  // Brightness levels
  localparam logic [7:0] LEVEL_FULL       = 8'd255;
  localparam logic [7:0] LEVEL_PULSE_INIT = 8'd128;
  localparam logic [7:0] LEVEL_FADE_INIT  = 8'd0;

  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    FX_SOLID  = 3'd0,
    FX_SLOW   = 3'd1,
    FX_MEDIUM = 3'd2,
    FX_FAST   = 3'd3,
    FX_PULSE  = 3'd4,
    FX_FADE   = 3'd5
  } fx_t;

  // Per-LED state as held in the state memory
  typedef struct packed {
    logic [23:0] target_grb;
    fx_t         effect_mode;
    logic [15:0] elapsed_ms;
    logic        blink_lit;
    logic [7:0]  level;
    logic        rising;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_RESET = '{
    target_grb:  24'd0,
    effect_mode: FX_SOLID,
    elapsed_ms:  16'd0,
    blink_lit:   1'b0,
    level:       LEVEL_FULL,
    rising:      1'b1
  };

  // Configuration registers
  typedef struct packed {
    logic [15:0] blink_slow_ms;
    logic [15:0] blink_medium_ms;
    logic [15:0] blink_fast_ms;
    logic [15:0] pulse_interval_ms;
    logic [15:0] fade_interval_ms;
    logic [6:0]  brightness_step;
    logic [7:0]  pulse_floor;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    blink_slow_ms:     16'd1000,
    blink_medium_ms:   16'd500,
    blink_fast_ms:     16'd100,
    pulse_interval_ms: 16'd20,
    fade_interval_ms:  16'd10,
    brightness_step:   7'd5,
    pulse_floor:       8'd32
  };

endpackage

@@ hw/rtl/lbpf_ram.sv @@
module lbpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/lbpf_update.sv @@
module lbpf_update (
  input  lbpf_pkg::entry_t cur,
  input  lbpf_pkg::cfg_t   cfg,
  output lbpf_pkg::entry_t nxt,
  output logic [23:0]      show_grb,
  output logic [7:0]       show_level
);

  import lbpf_pkg::*;

  logic [15:0]       elapsed_inc;
  logic [15:0]       period;
  logic              step_due;
  logic signed [9:0] pulse_nv;
  logic [8:0]        fade_sum;

  // Saturating elapsed time
  assign elapsed_inc = (cur.elapsed_ms != ELAPSED_MAX) ? cur.elapsed_ms + 16'd1
                                                       : cur.elapsed_ms;

  // Step period for the current effect
  always_comb begin
    case (cur.effect_mode)
      FX_SLOW:   period = cfg.blink_slow_ms;
      FX_MEDIUM: period = cfg.blink_medium_ms;
      FX_FAST:   period = cfg.blink_fast_ms;
      FX_PULSE:  period = cfg.pulse_interval_ms;
      default:   period = cfg.fade_interval_ms;
    endcase
  end

  assign step_due = (elapsed_inc >= period);

  // Pulse and fade candidate levels
  assign pulse_nv = cur.rising
    ? $signed({2'b00, cur.level}) + $signed({3'b000, cfg.brightness_step})
    : $signed({2'b00, cur.level}) - $signed({3'b000, cfg.brightness_step});
  assign fade_sum = {1'b0, cur.level} + {2'b00, cfg.brightness_step};

  // Effect step
  always_comb begin
    nxt = cur;
    nxt.elapsed_ms = elapsed_inc;
    if (cur.effect_mode != FX_SOLID && step_due) begin
      nxt.elapsed_ms = 16'd0;
      case (cur.effect_mode)
        FX_PULSE: begin
          if (pulse_nv >= $signed({2'b00, LEVEL_FULL})) begin
            nxt.level  = LEVEL_FULL;
            nxt.rising = 1'b0;
          end else if (pulse_nv <= $signed({2'b00, cfg.pulse_floor})) begin
            nxt.level  = cfg.pulse_floor;
            nxt.rising = 1'b1;
          end else begin
            nxt.level = pulse_nv[7:0];
          end
        end
        FX_FADE: begin
          if (cur.level != LEVEL_FULL) begin
            nxt.level = (fade_sum > {1'b0, LEVEL_FULL}) ? LEVEL_FULL : fade_sum[7:0];
          end
        end
        default: begin
          nxt.blink_lit = ~cur.blink_lit;
        end
      endcase
    end
  end

  // Color and brightness to display
  always_comb begin
    case (cur.effect_mode)
      FX_SOLID: begin
        show_grb   = cur.target_grb;
        show_level = LEVEL_FULL;
      end
      FX_PULSE, FX_FADE: begin
        show_grb   = cur.target_grb;
        show_level = nxt.level;
      end
      default: begin
        show_grb   = nxt.blink_lit ? cur.target_grb : 24'd0;
        show_level = LEVEL_FULL;
      end
    endcase
  end

endmodule

@@ hw/rtl/lbpf_scale.sv @@
module lbpf_scale (
  input  logic        clk,
  input  logic        load,
  input  logic [23:0] grb,
  input  logic [7:0]  level,
  output logic [23:0] result
);

  import lbpf_pkg::*;

  logic [15:0] prod_g;
  logic [15:0] prod_r;
  logic [15:0] prod_b;
  logic [23:0] raw_grb;
  logic        bypass;

  // floor(x / 255) for x up to 255*254, by reciprocal add
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  // Product stage
  always_ff @(posedge clk) begin
    if (load) begin
      prod_g  <= 16'(grb[23:16] * level);
      prod_r  <= 16'(grb[15:8] * level);
      prod_b  <= 16'(grb[7:0] * level);
      raw_grb <= grb;
      bypass  <= (level == LEVEL_FULL);
    end
  end

  assign result = bypass ? raw_grb : {div255(prod_g), div255(prod_r), div255(prod_b)};

endmodule

@@ hw/rtl/led_blink_pulse_fade_effects.sv @@
// Per-LED effect engine for GRB pixels. Each LED's color, effect, elapsed
// time, blink phase and brightness level live in one state memory with a
// registered read. A set command (command 1) writes one LED's entry in the
// cycle it is accepted; an index at or above LED_COUNT is dropped. An all-off
// command (command 2) returns every LED to solid black. A tick (command 0)
// walks the LEDs in index order: read, update and write back, multiply, then
// present the scaled color, through the states READ, UPD, SCALE and EMIT. An
// output stall holds the LED in EMIT, and a tick holds the input closed until
// its last LED has gone out. The engine handles one LED at a time through the
// single memory port pair and the one output register. The next command is
// taken in the cycle after the pixel flagged last_pixel has transferred.
// Configuration writes are taken at any time and must only be issued while
// the engine is idle. No clearing pass runs after reset.
module led_blink_pulse_fade_effects #(
  parameter int LED_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  led_sel,
  input  logic [23:0] grb_value,
  input  logic [2:0]  effect_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  pixel_index,
  output logic [23:0] pixel_grb,
  output logic        last_pixel
);

  import lbpf_pkg::*;

  localparam int IDX_W = $clog2(LED_COUNT);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_UPD   = 5'b00100,
    ST_SCALE = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t               state;
  logic [IDX_W-1:0]     led;
  logic                 led_last;
  logic [LED_COUNT-1:0] vld;
  cfg_t                 cfg;

  logic                 in_xfer;
  logic                 set_hit;
  fx_t                  set_fx;
  entry_t               set_entry;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;
  entry_t               cur;
  entry_t               upd_nxt;
  logic [23:0]          show_grb;
  logic [7:0]           show_level;
  logic [23:0]          scaled_grb;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BLINK_SLOW:  cfg.blink_slow_ms     <= cfg_wdata;
        REG_BLINK_MED:   cfg.blink_medium_ms   <= cfg_wdata;
        REG_BLINK_FAST:  cfg.blink_fast_ms     <= cfg_wdata;
        REG_PULSE_INTVL: cfg.pulse_interval_ms <= cfg_wdata;
        REG_FADE_INTVL:  cfg.fade_interval_ms  <= cfg_wdata;
        REG_BRIGHT_STEP: cfg.brightness_step   <= cfg_wdata[6:0];
        REG_PULSE_FLOOR: cfg.pulse_floor       <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign led_last = (led == IDX_W'(LED_COUNT - 1));

  // Entry written by a set command
  assign set_hit = in_xfer && (command == CMD_SET) && (led_sel < 8'(LED_COUNT));
  assign set_fx  = (effect_code > FX_FADE) ? FX_SOLID : fx_t'(effect_code);

  always_comb begin
    set_entry             = ENTRY_RESET;
    set_entry.target_grb  = grb_value;
    set_entry.effect_mode = set_fx;
    case (set_fx)
      FX_PULSE: set_entry.level = LEVEL_PULSE_INIT;
      FX_FADE:  set_entry.level = LEVEL_FADE_INIT;
      default:  set_entry.level = LEVEL_FULL;
    endcase
  end

  // State memory access
  assign ram_we    = set_hit || (state == ST_UPD);
  assign ram_waddr = (state == ST_UPD) ? led : led_sel[IDX_W-1:0];
  assign ram_wdata = (state == ST_UPD) ? upd_nxt : set_entry;

  lbpf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(LED_COUNT)
  ) u_state_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(led),
    .rdata(ram_rdata)
  );

  // An entry never written since reset or all-off reads as the reset entry
  assign cur = vld[led] ? entry_t'(ram_rdata) : ENTRY_RESET;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (in_xfer && command == CMD_ALL_OFF) begin
      vld <= '0;
    end else if (set_hit) begin
      vld[led_sel[IDX_W-1:0]] <= 1'b1;
    end else if (state == ST_UPD) begin
      vld[led] <= 1'b1;
    end
  end

  lbpf_update u_update (
    .cur       (cur),
    .cfg       (cfg),
    .nxt       (upd_nxt),
    .show_grb  (show_grb),
    .show_level(show_level)
  );

  lbpf_scale u_scale (
    .clk   (clk),
    .load  (state == ST_UPD),
    .grb   (show_grb),
    .level (show_level),
    .result(scaled_grb)
  );

  // Tick sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      led       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer && command == CMD_TICK) begin
            led   <= '0;
            state <= ST_READ;
          end
        end
        ST_READ:  state <= ST_UPD;
        ST_UPD:   state <= ST_SCALE;
        ST_SCALE: begin
          out_valid <= 1'b1;
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (led_last) begin
              state <= ST_IDLE;
            end else begin
              led   <= led + IDX_W'(1);
              state <= ST_READ;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == ST_SCALE) begin
      pixel_index <= 6'(led);
      pixel_grb   <= scaled_grb;
      last_pixel  <= led_last;
    end
  end

  // No new command while a pixel is pending
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while a pixel is pending");

  // Final pixel transfer ends the tick
  a_last_ends_tick: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_pixel) |=> in_ready)
    else $error("engine busy after final pixel");

  // Emitted index stays within the LED count
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pixel_index < 6'(LED_COUNT - 1) || pixel_index == 6'(LED_COUNT - 1)))
    else $error("pixel index out of range");

  // last_pixel only on the highest LED
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_pixel) |-> pixel_index == 6'(LED_COUNT - 1))
    else $error("last_pixel on wrong LED");

endmodule
